@@ src/segment_address_translator_defines.svh @@
// Assertion macros for the segment address translator.
`ifndef SEGMENT_ADDRESS_TRANSLATOR_DEFINES_SVH
`define SEGMENT_ADDRESS_TRANSLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SAT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAT_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);
`else
`define SAT_ASSERT(label, clk, rst_n, prop, msg)
`define SAT_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg)
`endif
`endif

@@ src/sat_pkg.sv @@
// Package: types, codes and constants of the segment address translator.
`default_nettype none
package sat_pkg;
  localparam int unsigned MaxExtents = 16;
  localparam int unsigned AddrW = 64;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0, CMD_BUILD = 3'd1, CMD_IDENTITY = 3'd2,
    CMD_TRANSLATE = 3'd3, CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_OVERLAP = 3'd1, ST_EXCEEDS = 3'd2,
    ST_NOT_MAPPED = 3'd3, ST_FULL = 3'd4
  } xlate_status_t;

  // configuration register indexes
  localparam logic [63:0] CFG_WINDOW_BASE = 64'd0;
  localparam logic [63:0] CFG_WINDOW_SIZE = 64'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_SORT_RD, S_SORT_CMP, S_SORT_WR, S_CHK_RD, S_CHK,
    S_LAY_RD, S_LAY, S_TR_RD, S_TR, S_OUT
  } state_t;
endpackage
`default_nettype wire

@@ src/sat_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none
interface sat_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] start_req;
  logic [63:0] length;
  modport source (output valid, command, start_req, length, input ready);
  modport sink (input valid, command, start_req, length, output ready);
endinterface

interface sat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] phys_start;
  logic [63:0] piece_length;
  logic [63:0] rest_start;
  logic [63:0] rest_length;
  modport source (output valid, status, phys_start, piece_length, rest_start,
                  rest_length, input ready);
  modport sink (input valid, status, phys_start, piece_length, rest_start,
                rest_length, output ready);
endinterface

interface sat_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/sat_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module sat_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ src/segment_address_translator.sv @@
// Top level: extent list, map build and translate over RAM-held tables.
//
//  channel | dir | handshake    | payload
//  in_     | in  | valid/ready  | command, start_req, length
//  out_    | out | valid/ready  | status, phys_start, piece_length, rest_*
//  cfg_    | in  | valid/ready  | index, data (window_base, window_size)
//
// Append, clear and identity go from idle straight to the output state;
// a translate scans the segment RAM entry by entry, up to the first segment
// that ends above the start. A build runs a bubble sort (N(N-1)/2 compares),
// then check and lay-out passes over the extents. No clearing pass after
// reset. One request at a time; a new request is taken once the result
// register has been handed over. Reset is synchronous, active low.
`default_nettype none
`include "segment_address_translator_defines.svh"
module segment_address_translator import sat_pkg::*; #(
  parameter int unsigned MAX_EXTENTS = MaxExtents
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sat_req_if.sink   in_ch,
  sat_rsp_if.source out_ch,
  sat_cfg_if.sink   cfg_ch
);
  localparam int unsigned IdxW = $clog2(MAX_EXTENTS);
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_EXTENTS);

  state_t state_r, state_nxt;
  logic [63:0] base_r, size_r;
  logic [CntW-1:0] ext_cnt_r, seg_cnt_r;
  logic [63:0] s_r, len_r;
  logic [IdxW-1:0] i_r;       // scan / pass index
  logic [CntW-1:0] pass_r;    // sort pass
  logic [63:0] a_st_r, a_ln_r; // held entry j
  logic [63:0] total_r, prev_end_r, prev_st_r, va_r;
  logic        rd_hi_r;       // sort: reading j+1
  logic        swap_r;
  logic        o_valid_r;
  logic [2:0]  o_status_r;
  logic [63:0] o_ph_r, o_pl_r, o_rs_r, o_rl_r;
  logic        sort_done, chk_fail, chk_last;
  logic [63:0] tot_sat;

  // RAM ports
  logic            ex_we, sg_we;
  logic [IdxW-1:0] ex_addr, sg_addr;
  logic [63:0]     ex_st_wd, ex_ln_wd, ex_st_rd, ex_ln_rd;
  logic [63:0]     sg_end_wd, sg_off_wd, sg_end_rd, sg_off_rd;

  sat_ram #(.Width(64), .Depth(MAX_EXTENTS)) u_ext_st (
    .clk, .we(ex_we), .addr(ex_addr), .wdata(ex_st_wd), .rdata(ex_st_rd));
  sat_ram #(.Width(64), .Depth(MAX_EXTENTS)) u_ext_ln (
    .clk, .we(ex_we), .addr(ex_addr), .wdata(ex_ln_wd), .rdata(ex_ln_rd));
  sat_ram #(.Width(64), .Depth(MAX_EXTENTS)) u_seg_end (
    .clk, .we(sg_we), .addr(sg_addr), .wdata(sg_end_wd), .rdata(sg_end_rd));
  sat_ram #(.Width(64), .Depth(MAX_EXTENTS)) u_seg_off (
    .clk, .we(sg_we), .addr(sg_addr), .wdata(sg_off_wd), .rdata(sg_off_rd));

  wire logic in_acc = in_ch.valid && in_ch.ready;
  wire logic o_acc  = out_ch.valid && out_ch.ready;
  wire logic [IdxW-1:0] i_inc = i_r + IdxW'(1);
  wire logic [CntW-1:0] i_ext = CntW'(i_r);

  // Derived arithmetic for the current memory read
  logic [64:0] sum65;
  logic [63:0] cur_end;
  logic [63:0] room;
  logic        last_cmp;
  always_comb begin
    sum65   = {1'b0, ex_st_rd} + {1'b0, ex_ln_rd};
    cur_end = sum65[64] ? '1 : sum65[63:0];
    room    = sg_end_rd - s_r;
    // last compare of this pass when j+1+pass == count-1
    last_cmp = (i_ext + CntW'(2) + pass_r) >= ext_cnt_r;
  end
  logic [64:0] tot65;
  assign tot65 = {1'b0, total_r} + {1'b0, ex_ln_rd};

  assign in_ch.ready  = rst_n && (state_r == S_IDLE) && !o_valid_r;
  assign cfg_ch.ready = rst_n && (state_r == S_IDLE);
  assign out_ch.valid = o_valid_r;
  assign out_ch.status = o_status_r;
  assign out_ch.phys_start = o_ph_r;
  assign out_ch.piece_length = o_pl_r;
  assign out_ch.rest_start = o_rs_r;
  assign out_ch.rest_length = o_rl_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        unique case (in_ch.command)
          CMD_BUILD: state_nxt = (ext_cnt_r > CntW'(1)) ? S_SORT_RD :
                                 (ext_cnt_r == '0) ? S_LAY_RD : S_CHK_RD;
          CMD_TRANSLATE: state_nxt = (seg_cnt_r == '0) ? S_OUT : S_TR_RD;
          default: state_nxt = S_OUT;
        endcase
      end
      S_SORT_RD:  state_nxt = rd_hi_r ? S_SORT_CMP : S_SORT_RD;
      S_SORT_CMP: state_nxt = S_SORT_WR;
      S_SORT_WR:  state_nxt = S_SORT_RD;
      S_CHK_RD:   state_nxt = S_CHK;
      S_CHK:      state_nxt = S_CHK_RD;
      S_LAY_RD:   state_nxt = S_LAY;
      S_LAY:      state_nxt = S_LAY_RD;
      S_TR_RD:    state_nxt = S_TR;
      S_TR:       state_nxt = S_TR_RD;
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
    // early exits on the flags computed in the block below
    if (state_r == S_SORT_WR && sort_done) state_nxt = S_CHK_RD;
    if (state_r == S_CHK && (chk_fail || chk_last)) state_nxt = chk_fail ? S_OUT :
        ((tot_sat > size_r) ? S_OUT : S_LAY_RD);
    if (state_r == S_LAY && (i_ext + CntW'(1) >= ext_cnt_r)) state_nxt = S_OUT;
    if (state_r == S_LAY_RD && ext_cnt_r == '0) state_nxt = S_OUT;
    if (state_r == S_TR && (s_r < sg_end_rd || i_ext + CntW'(1) >= seg_cnt_r))
      state_nxt = S_OUT;
  end

  always_comb begin
    sort_done = last_cmp && (pass_r + CntW'(1) >= ext_cnt_r - CntW'(1));
    chk_fail  = (i_r != '0) && (ex_st_rd <= prev_st_r || ex_st_rd < prev_end_r);
    chk_last  = i_ext + CntW'(1) >= ext_cnt_r;
    tot_sat   = (i_r == '0) ? ex_ln_rd : (tot65[64] ? '1 : tot65[63:0]);
  end

  // Memory port control
  always_comb begin
    ex_we = 1'b0; sg_we = 1'b0;
    ex_addr = i_r; sg_addr = i_r;
    ex_st_wd = s_r; ex_ln_wd = len_r;
    sg_end_wd = va_r + ex_ln_rd;
    sg_off_wd = ex_st_rd - va_r;
    unique case (state_r)
      S_IDLE: begin
        ex_addr = ext_cnt_r[IdxW-1:0];
        ex_st_wd = in_ch.start_req; ex_ln_wd = in_ch.length;
        ex_we = in_acc && in_ch.command == CMD_APPEND && in_ch.length != '0 &&
                ext_cnt_r < CntMax;
        sg_addr = '0;
        sg_end_wd = base_r + size_r; sg_off_wd = '0;
        sg_we = in_acc && in_ch.command == CMD_IDENTITY;
      end
      S_SORT_RD: ex_addr = rd_hi_r ? i_inc : i_r;
      S_SORT_CMP: begin
        // swap: write j+1 with held j when out of order
        ex_addr = i_inc; ex_st_wd = a_st_r; ex_ln_wd = a_ln_r;
        ex_we = a_st_r > ex_st_rd;
      end
      S_SORT_WR: begin
        ex_addr = i_r; ex_st_wd = s_r; ex_ln_wd = len_r;
        ex_we = swap_r;
      end
      S_LAY: sg_we = 1'b1;
      default: ;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; o_valid_r <= 1'b0;
      ext_cnt_r <= '0; seg_cnt_r <= '0;
      base_r <= '0; size_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_WINDOW_BASE) base_r <= cfg_ch.data;
        else if (cfg_ch.index == CFG_WINDOW_SIZE) size_r <= cfg_ch.data;
      end
      if (o_acc) o_valid_r <= 1'b0;
      if (state_r == S_OUT) o_valid_r <= 1'b1;
      if (ex_we && state_r == S_IDLE) ext_cnt_r <= ext_cnt_r + CntW'(1);
      if (in_acc && in_ch.command == CMD_CLEAR) ext_cnt_r <= '0;
      if (sg_we && state_r == S_IDLE) seg_cnt_r <= CntW'(1);
      if (state_r == S_LAY_RD && ext_cnt_r == '0) seg_cnt_r <= '0;
      if (state_r == S_LAY && state_nxt == S_OUT) seg_cnt_r <= ext_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        s_r <= in_ch.start_req; len_r <= in_ch.length;
        i_r <= '0; pass_r <= '0; rd_hi_r <= 1'b0; va_r <= base_r;
        o_status_r <= ST_OK;
        o_ph_r <= '0; o_pl_r <= '0; o_rs_r <= '0; o_rl_r <= '0;
        if (in_ch.command == CMD_APPEND && in_ch.length != '0 &&
            ext_cnt_r >= CntMax) o_status_r <= ST_FULL;
        if (in_ch.command == CMD_TRANSLATE) o_status_r <= ST_NOT_MAPPED;
      end
      S_SORT_RD: begin
        if (rd_hi_r) begin
          a_st_r <= ex_st_rd; a_ln_r <= ex_ln_rd;
        end
        rd_hi_r <= !rd_hi_r;
      end
      S_SORT_CMP: begin
        // ex_*_rd hold entry j+1 here
        swap_r <= a_st_r > ex_st_rd;
        s_r <= ex_st_rd; len_r <= ex_ln_rd;
      end
      S_SORT_WR: begin
        if (last_cmp) begin
          i_r <= '0; pass_r <= pass_r + CntW'(1);
        end else i_r <= i_inc;
        if (sort_done) i_r <= '0;
      end
      S_CHK: begin
        prev_st_r <= ex_st_rd; prev_end_r <= cur_end; total_r <= tot_sat;
        i_r <= chk_last ? '0 : i_inc;
        if (chk_fail) o_status_r <= ST_OVERLAP;
        else if (chk_last && tot_sat > size_r) o_status_r <= ST_EXCEEDS;
      end
      S_LAY: begin
        va_r <= sg_end_wd; i_r <= i_inc;
      end
      S_TR: begin
        i_r <= i_inc;
        if (s_r < sg_end_rd) begin
          o_status_r <= ST_OK;
          o_ph_r <= s_r + sg_off_rd;
          if (len_r > room) begin
            o_pl_r <= room; o_rs_r <= sg_end_rd; o_rl_r <= len_r - room;
          end else begin
            o_pl_r <= len_r; o_rs_r <= s_r + len_r; o_rl_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  `SAT_ASSERT(a_busy_no_ready, clk, rst_n,
    (state_r != S_IDLE) |-> !in_ch.ready, "ready while busy")
  `SAT_ASSERT(a_cnt_range, clk, rst_n,
    (ext_cnt_r <= CntMax) && (seg_cnt_r <= CntMax), "count overflow")
  `SAT_ASSERT_NEXT(a_out_after, clk, rst_n,
    (state_r == S_OUT), o_valid_r, "result lost")
endmodule
`default_nettype wire

@@ test/tb_sat_scoreboard.sv @@
// Scoreboard class: predicts translator results and checks them in order.
`timescale 1ns / 1ps
`default_nettype none
package tb_sat_sb_pkg;
  import sat_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] phys_start;
    logic [63:0] piece_length;
    logic [63:0] rest_start;
    logic [63:0] rest_length;
  } xlate_result_t;

  class xlate_scoreboard;
    logic [63:0] win_base, win_size;
    logic [63:0] ext_start[MaxExtents];
    logic [63:0] ext_len[MaxExtents];
    int unsigned ext_cnt;
    logic [63:0] seg_end[MaxExtents];
    logic [63:0] seg_off[MaxExtents];
    int unsigned seg_cnt;
    xlate_result_t pending[$];
    int unsigned errors;
    int unsigned n_results;
    int unsigned n_status[8];

    function new();
      win_base = '0;
      win_size = '0;
      ext_cnt = 0;
      seg_cnt = 0;
      errors = 0;
      n_results = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void set_reg(logic [63:0] idx, logic [63:0] val);
      if (idx == CFG_WINDOW_BASE) win_base = val;
      else if (idx == CFG_WINDOW_SIZE) win_size = val;
    endfunction

    // saturating 64-bit add
    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function logic [2:0] build_segments();
      logic [63:0] ts, tl, total, va, prev_end;
      int unsigned n;
      n = ext_cnt;
      // bubble sort by start
      for (int i = 1; i < n; i++)
        for (int j = 0; j + i < n; j++)
          if (ext_start[j] > ext_start[j+1]) begin
            ts = ext_start[j]; tl = ext_len[j];
            ext_start[j] = ext_start[j+1]; ext_len[j] = ext_len[j+1];
            ext_start[j+1] = ts; ext_len[j+1] = tl;
          end
      total = (n > 0) ? ext_len[0] : '0;
      for (int i = 1; i < n; i++) begin
        prev_end = add_sat(ext_start[i-1], ext_len[i-1]);
        if (ext_start[i] <= ext_start[i-1] || ext_start[i] < prev_end) return ST_OVERLAP;
        total = add_sat(total, ext_len[i]);
      end
      if (win_size < total) return ST_EXCEEDS;
      va = win_base;
      for (int i = 0; i < n; i++) begin
        seg_end[i] = va + ext_len[i];
        seg_off[i] = ext_start[i] - va;
        va = seg_end[i];
      end
      seg_cnt = n;
      return ST_OK;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic [2:0] cmd, logic [63:0] s, logic [63:0] len);
      xlate_result_t r;
      logic [63:0] room;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (len != 0) begin
            if (ext_cnt >= MaxExtents) r.status = ST_FULL;
            else begin
              ext_start[ext_cnt] = s;
              ext_len[ext_cnt] = len;
              ext_cnt++;
            end
          end
        end
        CMD_BUILD: r.status = build_segments();
        CMD_IDENTITY: begin
          seg_end[0] = win_base + win_size;
          seg_off[0] = '0;
          seg_cnt = 1;
        end
        CMD_TRANSLATE: begin
          r.status = ST_NOT_MAPPED;
          for (int i = 0; i < seg_cnt; i++) begin
            if (s < seg_end[i]) begin
              room = seg_end[i] - s;
              r.phys_start = s + seg_off[i];
              if (len > room) begin
                r.piece_length = room;
                r.rest_start = seg_end[i];
                r.rest_length = len - room;
              end else begin
                r.piece_length = len;
                r.rest_start = s + len;
              end
              r.status = ST_OK;
              break;
            end
          end
        end
        CMD_CLEAR: ext_cnt = 0;
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(xlate_result_t got);
      xlate_result_t exp;
      n_results++;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: status %0d", got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      n_status[exp.status]++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.phys_start !== exp.phys_start) begin
        $error("phys_start: expected %h, got %h", exp.phys_start, got.phys_start);
        errors++;
      end
      if (got.piece_length !== exp.piece_length) begin
        $error("piece_length: expected %h, got %h", exp.piece_length, got.piece_length);
        errors++;
      end
      if (got.rest_start !== exp.rest_start) begin
        $error("rest_start: expected %h, got %h", exp.rest_start, got.rest_start);
        errors++;
      end
      if (got.rest_length !== exp.rest_length) begin
        $error("rest_length: expected %h, got %h", exp.rest_length, got.rest_length);
        errors++;
      end
    endfunction
  endclass
endpackage
`default_nettype wire

@@ test/tb.sv @@
// Testbench top: drives requests and configuration, checks every result.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import sat_pkg::*;
  import tb_sat_sb_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 1200;

  logic clk;
  logic rst_n;
  sat_req_if in_ch();
  sat_rsp_if out_ch();
  sat_cfg_if cfg_ch();

  segment_address_translator u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  xlate_scoreboard sb = new();
  int unsigned cycles;
  bit long_hold;
  int unsigned n_requests;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.command = '0; in_ch.start_req = '0; in_ch.length = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    long_hold = 1'b0;
    n_requests = 0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
  initial cycles = 0;

  // random gap: mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.phys_start, out_ch.piece_length,
                       out_ch.rest_start, out_ch.rest_length});
  end

  initial begin
    int unsigned g;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      g = gap_len();
      if (g > 0 && $urandom_range(3) != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // valid stays up after an accept; the next request with a gap or a drain drops it
  task automatic send_request(logic [2:0] cmd, logic [63:0] s, logic [63:0] len,
                              bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.start_req <= s;
    in_ch.length <= len;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(cmd, s, len);
    n_requests++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [63:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(logic [63:0] base, logic [63:0] size);
    wait_drained();
    write_reg(CFG_WINDOW_BASE, base);
    write_reg(CFG_WINDOW_SIZE, size);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // a clear, then a well-formed set of non-overlapping extents, shuffled, then a build
  task automatic build_random_map(int unsigned n, logic [63:0] max_len);
    logic [63:0] st[$];
    logic [63:0] ln[$];
    logic [63:0] p;
    int unsigned k;
    send_request(CMD_CLEAR, rand64(), rand64());
    p = {32'd0, $urandom()};
    for (int i = 0; i < n; i++) begin
      p = p + 64'($urandom_range(4096));
      st.push_back(p);
      ln.push_back(64'($urandom_range(32'(max_len), 1)));
      p = p + ln[i];
    end
    while (st.size() > 0) begin
      k = $urandom_range(st.size() - 1);
      send_request(CMD_APPEND, st[k], ln[k]);
      st.delete(k);
      ln.delete(k);
    end
    send_request(CMD_BUILD, rand64(), rand64());
  endtask

  task automatic random_request();
    int unsigned p;
    logic [63:0] s, len;
    p = $urandom_range(99);
    s = sb.win_base + 64'($urandom_range(20000));
    len = 64'($urandom_range(6000));
    if ($urandom_range(9) == 0) s = rand64();
    if ($urandom_range(9) == 0) len = rand64();
    if (p < 70) send_request(CMD_TRANSLATE, s, len);
    else if (p < 82) send_request(CMD_APPEND, rand64(), len);
    else if (p < 88) send_request(CMD_BUILD, s, len);
    else if (p < 92) send_request(CMD_IDENTITY, s, len);
    else if (p < 96) send_request(CMD_CLEAR, s, len);
    else send_request(3'($urandom_range(7, 5)), s, len);
  endtask

  initial begin
    int unsigned phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty map, extremes, identity, overlaps, full list, saturation
    send_request(CMD_TRANSLATE, '0, '0);
    send_request(CMD_BUILD, '0, '0);
    send_request(CMD_TRANSLATE, '1, '1);
    set_window(64'hFFFF_FFFF_FFFF_F000, 64'h2000);
    send_request(CMD_IDENTITY, '0, '0);
    send_request(CMD_TRANSLATE, 64'hFFFF_FFFF_FFFF_FF00, 64'h100);
    send_request(CMD_TRANSLATE, 64'h0, 64'h2000);
    send_request(CMD_APPEND, 64'h1000, 64'h0);
    send_request(CMD_APPEND, 64'h5000, 64'h100);
    send_request(CMD_APPEND, 64'h5000, 64'h100);
    send_request(CMD_BUILD, '0, '0);
    send_request(CMD_CLEAR, '1, '1);
    send_request(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FF00, 64'h1000);
    send_request(CMD_APPEND, 64'h10, 64'h10);
    send_request(CMD_BUILD, '0, '0);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_APPEND, 64'h0, '1);
    send_request(CMD_APPEND, '1, '1);
    send_request(CMD_BUILD, '0, '0);
    send_request(3'd7, '1, '1);
    set_window('0, '1);
    send_request(CMD_CLEAR, '0, '0);
    for (int i = 0; i < 17; i++) send_request(CMD_APPEND, 64'h1000 * 64'(i), 64'h800);
    send_request(CMD_BUILD, '0, '0);
    send_request(CMD_TRANSLATE, 64'h700, 64'h900);

    // random phases with varied windows
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: set_window(rand64(), '1);
        1: set_window({32'd0, $urandom()}, 64'h10000);
        2: set_window('1, '0);
        default: set_window('0, {32'd0, $urandom()});
      endcase
      if (phase == 5) long_hold = 1'b1;
      build_random_map($urandom_range(16, 1), 64'd3000);
      for (int i = 0; i < 80; i++) random_request();
      if (phase == 7) begin
        // sender waits for every outstanding result before resuming
        wait_drained();
        for (int i = 0; i < 12; i++)
          send_request(CMD_TRANSLATE, sb.win_base + 64'(100 * i), 64'd300, 1);
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d requests, %0d results (ok %0d, overlap %0d, exceeds %0d,",
             n_requests, sb.n_results, sb.n_status[ST_OK], sb.n_status[ST_OVERLAP],
             sb.n_status[ST_EXCEEDS]);
    $display("  not mapped %0d, list full %0d) over 14 window settings",
             sb.n_status[ST_NOT_MAPPED], sb.n_status[ST_FULL]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
